FILE: design/igrr_pkg.sv
// shared types and constants for the int8 gemm row requantizer
package igrr_pkg;

   localparam int COLS_DEFAULT = 8;
   localparam int COLS_MAX     = 8;
   localparam int ACC_W        = 32;
   localparam int FRAC_W       = 24;
   localparam int OUT_MAX      = 127;

   // per-cycle control broadcast to every lane cell
   typedef struct packed {
      logic accept;   // input transaction taken this cycle
      logic first;    // start from the row bias
      logic load;     // copy the updated accumulator into the drain chain
      logic shift;    // drain chain moves one cell toward lane 0
   } cell_ctrl_type;

endpackage

FILE: design/igrr_cell.sv
// one lane cell: 32-bit multiply-accumulate plus one stage of the drain chain
module igrr_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  igrr_pkg::cell_ctrl_type     ctrl,
   input  logic signed [7:0]           act_value,
   input  logic signed [7:0]           weight,
   input  logic [igrr_pkg::ACC_W-1:0]  row_bias,
   input  logic [igrr_pkg::ACC_W-1:0]  snap_next,
   output logic [igrr_pkg::ACC_W-1:0]  snap_out
);

   logic [igrr_pkg::ACC_W-1:0] acc_ff;
   logic [igrr_pkg::ACC_W-1:0] acc_in;
   logic [igrr_pkg::ACC_W-1:0] snap_ff;
   logic [igrr_pkg::ACC_W-1:0] snap_in;
   logic [igrr_pkg::ACC_W-1:0] acc_base;
   logic signed [15:0]         prod;

   always_comb begin
      prod     = act_value * weight;
      acc_base = ctrl.first ? row_bias : acc_ff;
      acc_in   = acc_ff;
      if (ctrl.accept) begin
         acc_in = acc_base + {{(igrr_pkg::ACC_W-16){prod[15]}}, prod};
      end
      snap_in = snap_ff;
      if (ctrl.accept && ctrl.load) begin
         snap_in = acc_in;
      end else if (ctrl.shift) begin
         snap_in = snap_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign snap_out = snap_ff;

endmodule

FILE: design/igrr_requant.sv
// shared requantizer: q8.24 scale multiply, round half to even, clamp, zero point
module igrr_requant (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [igrr_pkg::ACC_W-1:0]  acc,
   input  logic [igrr_pkg::ACC_W-1:0]  scale,
   input  logic signed [7:0]           out_offset,
   output logic                        out_valid,
   output logic [7:0]                  out_byte
);

   localparam int PROD_W = 2 * igrr_pkg::ACC_W;
   localparam int Q_W    = PROD_W - igrr_pkg::FRAC_W;

   logic                       p1_valid_ff;
   logic [PROD_W-1:0]          p1_prod_ff;
   logic                       p1_nonpos_ff;
   logic                       out_valid_ff;
   logic [7:0]                 out_byte_ff;
   logic [7:0]                 out_byte_in;

   logic [Q_W-1:0]             q;
   logic [igrr_pkg::FRAC_W-1:0] rem;
   logic                       round_up;
   logic [Q_W:0]               q_r;
   logic [8:0]                 hi;
   logic                       over;
   logic [8:0]                 lim;

   always_comb begin
      q        = p1_prod_ff[PROD_W-1:igrr_pkg::FRAC_W];
      rem      = p1_prod_ff[igrr_pkg::FRAC_W-1:0];
      // ties go to the even quotient
      round_up = (rem > {1'b1, {(igrr_pkg::FRAC_W-1){1'b0}}}) ||
                 ((rem == {1'b1, {(igrr_pkg::FRAC_W-1){1'b0}}}) && q[0]);
      q_r      = {1'b0, q} + {{Q_W{1'b0}}, round_up};
      hi       = 9'(9'(igrr_pkg::OUT_MAX) - {out_offset[7], out_offset});
      over     = (|q_r[Q_W:9]) || (q_r[8:0] > hi);
      lim      = over ? hi : q_r[8:0];
      if (p1_nonpos_ff) begin
         lim = '0;
      end
      out_byte_in = lim[7:0] + out_offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= in_valid;
         out_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_prod_ff   <= PROD_W'(acc) * PROD_W'(scale);
      p1_nonpos_ff <= acc[igrr_pkg::ACC_W-1] || (acc == '0);
      out_byte_ff  <= out_byte_in;
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;

endmodule

FILE: design/int8_gemm_row_requant_relu.sv
// top level: row of mac cells, drain chain into one requantizer, output register
//
// Input channel (req_*): one transaction per inner-dimension step, carrying one
// signed activation byte and COLS signed weight bytes. A first_step transaction
// restarts every lane accumulator from row_bias; each transaction adds
// act_value * weight per lane with 32-bit wraparound.
// Steps without last_step are taken one per cycle while req_stall is low and produce nothing.
// A last_step transaction copies the lane sums into a drain chain that shifts
// one lane per cycle into a single pipelined requantizer (multiply, then round,
// clamp and zero point). The packed result is assembled from the requantizer
// bytes and shows on rsp_*; req_stall stays high from the taken last step until
// the result is moved into the output register.
// Once the result sits in the output register the input is free again, so the
// next row accumulates while a stalled result waits on rsp_stall.
// If that result is still waiting when the next row has drained, req_stall
// stays high until it is taken.
// Output bytes of lanes at and above COLS are zero.
// Reset clears the accumulators, the output offset and all valid flags.
// csr_wr_en writes the output offset; write it only while the block is idle.
module int8_gemm_row_requant_relu #(
   parameter int COLS = igrr_pkg::COLS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [7:0]  req_act_value,
   input  logic [63:0]        req_weight_lanes,
   input  logic signed [31:0] req_row_bias,
   input  logic [31:0]        req_scale_mult,
   input  logic               req_first_step,
   input  logic               req_last_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_out_lanes,
   input  logic               csr_wr_en,
   input  logic signed [7:0]  csr_wr_data
);

   localparam int CNT_W = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ASM_W = COLS * 8;

   logic                          busy_ff;
   logic                          feed_ff;
   logic [CNT_W-1:0]              feed_cnt_ff;
   logic [CNT_W-1:0]              asm_cnt_ff;
   logic                          done_ff;
   logic [ASM_W-1:0]              asm_ff;
   logic                          rsp_valid_ff;
   logic [63:0]                   rsp_lanes_ff;
   logic [31:0]                   scale_ff;
   logic signed [7:0]             out_offset_ff;

   logic                          accept;
   logic                          transfer;
   igrr_pkg::cell_ctrl_type       ctrl;
   logic [igrr_pkg::ACC_W-1:0]    snap_chain [COLS+1];
   logic                          rq_valid;
   logic [7:0]                    rq_byte;

   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign transfer  = done_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      ctrl.accept = accept;
      ctrl.first  = req_first_step;
      ctrl.load   = req_last_step;
      ctrl.shift  = feed_ff;
   end

   assign snap_chain[COLS] = '0;

   for (genvar i = 0; i < COLS; i++) begin : g_cell
      igrr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .act_value (req_act_value),
         .weight    (req_weight_lanes[8*i +: 8]),
         .row_bias  (req_row_bias),
         .snap_next (snap_chain[i+1]),
         .snap_out  (snap_chain[i])
      );
   end

   igrr_requant u_requant (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (feed_ff),
      .acc        (snap_chain[0]),
      .scale      (scale_ff),
      .out_offset (out_offset_ff),
      .out_valid  (rq_valid),
      .out_byte   (rq_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         feed_ff       <= 1'b0;
         feed_cnt_ff   <= '0;
         asm_cnt_ff    <= '0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         out_offset_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            out_offset_ff <= csr_wr_data;
         end
         if (accept && req_last_step) begin
            busy_ff     <= 1'b1;
            feed_ff     <= 1'b1;
            feed_cnt_ff <= '0;
         end else if (feed_ff) begin
            feed_cnt_ff <= feed_cnt_ff + 1'b1;
            if (feed_cnt_ff == CNT_W'(COLS - 1)) begin
               feed_ff <= 1'b0;
            end
         end
         if (rq_valid) begin
            if (asm_cnt_ff == CNT_W'(COLS - 1)) begin
               asm_cnt_ff <= '0;
               done_ff    <= 1'b1;
            end else begin
               asm_cnt_ff <= asm_cnt_ff + 1'b1;
            end
         end
         if (transfer) begin
            done_ff      <= 1'b0;
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_step) begin
         scale_ff <= req_scale_mult;
      end
      if (rq_valid) begin
         asm_ff[8*asm_cnt_ff +: 8] <= rq_byte;
      end
      if (transfer) begin
         rsp_lanes_ff <= 64'(asm_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_lanes = rsp_lanes_ff;

endmodule

FILE: tb/sv/int8_gemm_row_checker.sv
// lane accumulator predictor and result comparison for the int8 gemm row requantizer
module int8_gemm_row_checker #(
   parameter int COLS = igrr_pkg::COLS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [7:0]  req_act_value,
   input  logic [63:0]        req_weight_lanes,
   input  logic signed [31:0] req_row_bias,
   input  logic [31:0]        req_scale_mult,
   input  logic               req_first_step,
   input  logic               req_last_step,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [63:0]        rsp_out_lanes,
   input  logic               csr_wr_en,
   input  logic signed [7:0]  csr_wr_data,
   output int                 mismatch_count,
   output int                 rows_pending,
   output int                 rows_checked
);

   localparam int REPORT_LIMIT = 10;

   logic [igrr_pkg::ACC_W-1:0] lane_acc [igrr_pkg::COLS_MAX];
   logic signed [7:0]          out_offset = '0;
   logic [63:0]                expected_rows [$];
   int                         errors  = 0;
   int                         checked = 0;

   // unsigned Q8.24 multiply, round half to even, clamp to [0, 127 - zp], add zp
   function automatic logic [7:0] requantize_lane(input logic [igrr_pkg::ACC_W-1:0] acc,
                                                  input logic [31:0] scale,
                                                  input logic signed [7:0] zp);
      int         upper;
      int         level;
      logic [63:0] product;
      logic [63:0] whole;
      logic [igrr_pkg::FRAC_W-1:0] frac;
      upper = igrr_pkg::OUT_MAX - int'(zp);
      if (acc[igrr_pkg::ACC_W-1] || acc == '0) begin
         level = 0;
      end else begin
         product = {32'b0, acc} * {32'b0, scale};
         whole   = product >> igrr_pkg::FRAC_W;
         frac    = product[igrr_pkg::FRAC_W-1:0];
         if (frac > 24'h800000 || (frac == 24'h800000 && whole[0]))
            whole = whole + 64'd1;
         if (whole > 64'(upper))
            level = upper;
         else
            level = int'(whole);
      end
      level = level + int'(zp);
      return level[7:0];
   endfunction

   always @(posedge clock) begin : watch
      logic [63:0]       want;
      logic [63:0]       packed_out;
      logic signed [7:0] weight;
      if (reset) begin
         foreach (lane_acc[i]) lane_acc[i] = '0;
         out_offset = '0;
         expected_rows.delete();
      end else begin
         if (csr_wr_en)
            out_offset = csr_wr_data;

         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected result transaction out_lanes=%h", rsp_out_lanes);
            end else begin
               want = expected_rows.pop_front();
               checked++;
               if (rsp_out_lanes !== want) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("out_lanes mismatch on row %0d: expected %h, got %h",
                              checked, want, rsp_out_lanes);
               end
            end
         end

         if (req_valid && !req_stall) begin
            for (int i = 0; i < igrr_pkg::COLS_MAX; i++) begin
               if (i < COLS) begin
                  weight = req_weight_lanes[8*i +: 8];
                  if (req_first_step)
                     lane_acc[i] = req_row_bias;
                  lane_acc[i] = lane_acc[i] + 32'(int'(req_act_value) * int'(weight));
               end
            end
            if (req_last_step) begin
               packed_out = '0;
               for (int i = 0; i < COLS; i++)
                  packed_out[8*i +: 8] = requantize_lane(lane_acc[i], req_scale_mult,
                                                         out_offset);
               expected_rows.push_back(packed_out);
            end
         end
      end
      mismatch_count <= errors;
      rows_pending   <= expected_rows.size();
      rows_checked   <= checked;
   end

endmodule

FILE: tb/sv/int8_gemm_row_requant_relu_test.sv
// stimulus, handshake pacing and verdict for the int8 gemm row requantizer
module int8_gemm_row_requant_relu_test;

   localparam int COLS        = igrr_pkg::COLS_DEFAULT;
   localparam int SETTLE      = COLS + 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 250;
   localparam int PHASE_STEPS = 290;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [7:0]  req_act_value;
   logic [63:0]        req_weight_lanes;
   logic signed [31:0] req_row_bias;
   logic [31:0]        req_scale_mult;
   logic               req_first_step;
   logic               req_last_step;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [63:0]        rsp_out_lanes;
   logic               csr_wr_en;
   logic signed [7:0]  csr_wr_data;

   int mismatch_count;
   int rows_pending;
   int rows_checked;
   int cycle_count = 0;
   int steps_sent  = 0;
   int sender_idle_pct   = 31;
   int receiver_idle_pct = 88;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   always #10 clock = ~clock;

   int8_gemm_row_requant_relu #(.COLS(COLS)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_act_value    (req_act_value),
      .req_weight_lanes (req_weight_lanes),
      .req_row_bias     (req_row_bias),
      .req_scale_mult   (req_scale_mult),
      .req_first_step   (req_first_step),
      .req_last_step    (req_last_step),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_lanes    (rsp_out_lanes),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   int8_gemm_row_checker #(.COLS(COLS)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_act_value    (req_act_value),
      .req_weight_lanes (req_weight_lanes),
      .req_row_bias     (req_row_bias),
      .req_scale_mult   (req_scale_mult),
      .req_first_step   (req_first_step),
      .req_last_step    (req_last_step),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_lanes    (rsp_out_lanes),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .rows_pending     (rows_pending),
      .rows_checked     (rows_checked)
   );

   // result side: random stalls plus an occasional long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_served < hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d rows still expected", cycle_count,
                  rows_pending);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_step(input logic signed [7:0] act, input logic [63:0] weights,
                            input logic [31:0] bias, input logic [31:0] scale,
                            input logic first, input logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_act_value    <= act;
      req_weight_lanes <= weights;
      req_row_bias     <= bias;
      req_scale_mult   <= scale;
      req_first_step   <= first;
      req_last_step    <= last;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      steps_sent++;
   endtask

   // stop offering until every row result is back, then let the pipe empty
   task automatic wait_for_rows();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_out_offset(input logic signed [7:0] zp);
      csr_wr_data <= zp;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [31:0] pick_bias();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($urandom_range(0, 4000));
         2: return 32'(int'($urandom_range(0, 8000)) - 4000);
         default: return '0;
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(32'h1000, 32'h40000);
         2: return $urandom_range(0, 32'h1000000);
         3: begin
            case ($urandom_range(0, 3))
               0: return 32'h00800000;
               1: return 32'h01000000;
               2: return 32'h01800000;
               default: return 32'h00400000;
            endcase
         end
         default: return $urandom_range(32'h100, 32'h4000);
      endcase
   endfunction

   function automatic logic [7:0] pick_act();
      case ($urandom_range(0, 7))
         0: return 8'h80;
         1: return 8'h7f;
         2: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_weights();
      case ($urandom_range(0, 9))
         0: return {8{8'h80}};
         1: return {8{8'h7f}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic run_random_rows(input int step_budget);
      int start;
      int len;
      int kind;
      logic [31:0] bias;
      logic [31:0] scale;
      start = steps_sent;
      while (steps_sent - start < step_budget) begin
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            // well-formed row with random content
            len   = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 16)
                                                  : $urandom_range(1, 6);
            bias  = pick_bias();
            scale = pick_scale();
            for (int k = 0; k < len; k++)
               send_step(pick_act(), pick_weights(), (k == 0) ? bias : $urandom,
                         (k == len - 1) ? scale : $urandom, k == 0, k == len - 1);
         end else if (kind < 90) begin
            // stray steps that pile onto whatever the lanes hold
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++)
               send_step(pick_act(), pick_weights(), $urandom, pick_scale(), 1'b0,
                         1'($urandom));
         end else begin
            // row that is started and abandoned
            len = $urandom_range(1, 2);
            for (int k = 0; k < len; k++)
               send_step(pick_act(), pick_weights(), pick_bias(), $urandom, k == 0, 1'b0);
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_act_value    = '0;
      req_weight_lanes = '0;
      req_row_bias     = '0;
      req_scale_mult   = '0;
      req_first_step   = 1'b0;
      req_last_step    = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset zero point
      // lanes start from zero after reset, no first step
      send_step(8'h7f, {8{8'h7f}}, 32'h12345678, 32'h01000000, 1'b0, 1'b1);
      // most negative bias gives a negative sum, lanes fall to the zero point
      send_step(8'h80, {8{8'h80}}, 32'h80000000, 32'h01000000, 1'b1, 1'b1);
      // largest positive bias with largest scale saturates
      send_step(8'h80, {8{8'h7f}}, 32'h7fffffff, 32'hffffffff, 1'b1, 1'b1);
      // exact zero sum
      send_step(8'h00, {8{8'hff}}, 32'h00000000, 32'hffffffff, 1'b1, 1'b1);
      // lane sums 1..8 at scale one half and one and a half: ties round to even
      send_step(8'h01, 64'h0807060504030201, 32'h0, 32'h00800000, 1'b1, 1'b1);
      send_step(8'h01, 64'h0807060504030201, 32'h0, 32'h01800000, 1'b1, 1'b1);
      // zero scale
      send_step(8'h05, 64'h0807060504030201, 32'h64, 32'h00000000, 1'b1, 1'b1);
      // four step row with mixed signs
      send_step(8'h03, 64'h807f01ff10f0007f, 32'd100, 32'hdeadbeef, 1'b1, 1'b0);
      send_step(8'hf9, 64'h7f80ff0102fe4000, 32'hffffffff, 32'h0, 1'b0, 1'b0);
      send_step(8'h7f, 64'h0102030405060708, 32'h0, 32'h0, 1'b0, 1'b0);
      send_step(8'h80, 64'hf8f9fafbfcfdfeff, 32'h0, 32'h00100000, 1'b0, 1'b1);
      // accumulator wraps past the top of the 32-bit range
      send_step(8'h7f, {8{8'h7f}}, 32'h7fffff00, 32'h0, 1'b1, 1'b0);
      send_step(8'h7f, {8{8'h7f}}, 32'h0, 32'h00000001, 1'b0, 1'b1);
      // abandoned row, then a fresh single-step row
      send_step(8'h40, 64'hffffffffffffffff, 32'd5000, 32'h0, 1'b1, 1'b0);
      send_step(8'h02, 64'h807f807f807f807f, 32'd300, 32'h00040000, 1'b1, 1'b1);
      // carry on from the previous row's sums without a new bias
      send_step(8'hff, 64'h0000000000000001, 32'h0, 32'h01000000, 1'b0, 1'b1);
      wait_for_rows();

      // lowest zero point gives the full signed output range
      set_out_offset(-8'sd128);
      run_random_rows(PHASE_STEPS);
      wait_for_rows();

      sender_idle_pct   = 88;
      receiver_idle_pct = 31;
      // highest zero point pins every lane to the top
      set_out_offset(8'sd127);
      run_random_rows(PHASE_STEPS / 2);
      wait_for_rows();
      set_out_offset(8'($urandom_range(0, 40)) - 8'sd20);
      run_random_rows(PHASE_STEPS / 2);
      wait_for_rows();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      set_out_offset(8'($urandom));
      hold_requests++;
      run_random_rows(PHASE_STEPS);
      wait_for_rows();
      set_out_offset(8'sd0);
      run_random_rows(PHASE_STEPS);
      wait_for_rows();

      $display("sent %0d steps and checked %0d row results across zero points -128, 127,",
               steps_sent, rows_checked);
      $display("random and zero, with input and output stalls and one long output hold");
      if (mismatch_count == 0 && rows_pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
